// File: hdl/aes_pkg.sv
//------------------------------------------------------------------------------
// AES package
// Shared types, tables and round functions for the AES block encryptor.
//------------------------------------------------------------------------------
package aes_pkg;

    typedef enum logic [2:0] {
        t_ST_IDLE   = 3'd0,
        t_ST_EXPAND = 3'd1,
        t_ST_LOAD   = 3'd2,
        t_ST_ROUND  = 3'd3,
        t_ST_DONE   = 3'd4
    } t_state;

    localparam logic [2:0] REG_KEY0 = 3'd0;
    localparam logic [2:0] REG_KEY1 = 3'd1;
    localparam logic [2:0] REG_KEY2 = 3'd2;
    localparam logic [2:0] REG_KEY3 = 3'd3;
    localparam logic [2:0] REG_MODE = 3'd4;

    typedef struct packed {
        logic exp_start;
        logic exp_step;
        logic blk_load;
        logic key_add;
        logic rnd_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic exp_last;
        logic rnd_last;
    } t_status;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] x);
        return {sbox(x[31:24]), sbox(x[23:16]), sbox(x[15:8]), sbox(x[7:0])};
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] v);
        logic [7:0] a0, a1, a2, a3;
        a0 = v[31:24];
        a1 = v[23:16];
        a2 = v[15:8];
        a3 = v[7:0];
        return {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
                xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] i);
        logic [7:0] r;
        unique case (i)
            4'd1:    r = 8'h01;
            4'd2:    r = 8'h02;
            4'd3:    r = 8'h04;
            4'd4:    r = 8'h08;
            4'd5:    r = 8'h10;
            4'd6:    r = 8'h20;
            4'd7:    r = 8'h40;
            4'd8:    r = 8'h80;
            4'd9:    r = 8'h1b;
            4'd10:   r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

// File: hdl/aes_block_encrypt.sv
//------------------------------------------------------------------------------
// AES block encrypt
// Top level: AES-128/192/256 encryption of one 128-bit block per item.
//------------------------------------------------------------------------------
// Input channel i_in_valid/o_in_stall carries a plaintext beat; output channel
// o_out_valid/i_out_stall returns the ciphertext beat.
// Key registers and the mode are written through i_cfg_we/i_cfg_index/
// i_cfg_data; the user must do so only while idle, which the block does not
// enforce. Any write to a key or mode register marks the schedule stale.
// The first block after a key change expands the schedule, one word per
// cycle, 44, 52 or 60 words, before the rounds start. Per block: the accept
// cycle, the initial key add, one round per cycle on the shared round unit
// (Nr = 10, 12 or 14), and the load of the output register. A new plaintext
// beat is taken only once the previous block has reached the output register,
// as the single round unit serves one block at a time. The result sits in an
// output register until taken; while the receiver stalls with that register
// full, the next block waits in its done state and the input stays stalled.
// Reset clears the key registers, the mode and the schedule-ready flag.
module aes_block_encrypt #(
    parameter int ROUND_KEY_WORDS = 60
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [63:0] i_plain_high,
    input  logic [63:0] i_plain_low,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_cipher_high,
    output logic [63:0] o_cipher_low
);
    aes_pkg::t_cmd    cmd;
    aes_pkg::t_status status;

    aes_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    aes_dp #(.ROUND_KEY_WORDS(ROUND_KEY_WORDS)) u_dp (
        .i_clk         (i_clk),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_plain_high  (i_plain_high),
        .i_plain_low   (i_plain_low),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_cipher_high (o_cipher_high),
        .o_cipher_low  (o_cipher_low),
        .i_rst_n       (i_rst_n)
    );
endmodule

// File: hdl/aes_ram.sv
//------------------------------------------------------------------------------
// AES generic RAM
// Single write port, one registered read port.
//------------------------------------------------------------------------------
module aes_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 60
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: hdl/aes_ctrl.sv
//------------------------------------------------------------------------------
// AES controller
// Sequences key expansion, block load, rounds and result handoff.
//------------------------------------------------------------------------------
module aes_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_index,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    input  aes_pkg::t_status i_status,
    output aes_pkg::t_cmd    o_cmd
);
    aes_pkg::t_state r_state, n_state;
    logic r_ready, n_ready;
    logic r_ovalid, n_ovalid;
    logic cfg_hit;
    logic take;

    assign cfg_hit = i_cfg_we && (i_cfg_index <= aes_pkg::REG_MODE);
    assign take = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= aes_pkg::t_ST_IDLE;
            r_ready  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ready  <= n_ready;
            r_ovalid <= n_ovalid;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ready = r_ready;
        if (cfg_hit) begin
            n_ready = 1'b0;
        end
        unique case (r_state)
            aes_pkg::t_ST_IDLE: begin
                if (take) begin
                    n_state = r_ready ? aes_pkg::t_ST_LOAD : aes_pkg::t_ST_EXPAND;
                end
            end
            aes_pkg::t_ST_EXPAND: begin
                if (i_status.exp_last) begin
                    n_state = aes_pkg::t_ST_LOAD;
                    n_ready = 1'b1;
                end
            end
            aes_pkg::t_ST_LOAD:  n_state = aes_pkg::t_ST_ROUND;
            aes_pkg::t_ST_ROUND: begin
                if (i_status.rnd_last) begin
                    n_state = aes_pkg::t_ST_DONE;
                end
            end
            aes_pkg::t_ST_DONE: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_state = aes_pkg::t_ST_IDLE;
                end
            end
            default: n_state = aes_pkg::t_ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        n_ovalid = r_ovalid && i_out_stall;
        o_in_stall = (r_state != aes_pkg::t_ST_IDLE);
        unique case (r_state)
            aes_pkg::t_ST_IDLE: begin
                o_cmd.exp_start = take && !r_ready;
                o_cmd.blk_load  = take;
            end
            aes_pkg::t_ST_EXPAND: o_cmd.exp_step = 1'b1;
            aes_pkg::t_ST_LOAD:   o_cmd.key_add  = 1'b1;
            aes_pkg::t_ST_ROUND:  o_cmd.rnd_step = 1'b1;
            aes_pkg::t_ST_DONE: begin
                if (!r_ovalid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_ovalid = 1'b1;
                end
            end
            default: o_cmd = '0;
        endcase
    end

    assign o_out_valid = r_ovalid;
endmodule

// File: hdl/aes_dp.sv
//------------------------------------------------------------------------------
// AES datapath
// Key-schedule unit, round key store and shared single-round unit.
//------------------------------------------------------------------------------
module aes_dp #(
    parameter int ROUND_KEY_WORDS = 60
) (
    input  logic             i_clk,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_index,
    input  logic [63:0]      i_cfg_data,
    input  logic [63:0]      i_plain_high,
    input  logic [63:0]      i_plain_low,
    input  aes_pkg::t_cmd    i_cmd,
    output aes_pkg::t_status o_status,
    output logic [63:0]      o_cipher_high,
    output logic [63:0]      o_cipher_low,
    input  logic             i_rst_n
);
    localparam int ROW_DEPTH = (ROUND_KEY_WORDS + 3) / 4;
    localparam int AW = $clog2(ROW_DEPTH);

    logic [63:0]  r_key [4];
    logic [1:0]   r_mode;
    logic [3:0]   nk;
    logic [3:0]   nr;
    logic [5:0]   total;

    // expansion: window of the last eight words
    logic [31:0]  r_win [8];
    logic [5:0]   r_ei;
    logic [3:0]   r_emod;
    logic [3:0]   r_ediv;
    logic [31:0]  prev, back, tw, w;

    // round key rows: row r holds words 4r..4r+3, word 4r on top
    logic         rk_we;
    logic [127:0] rk_wdata;
    logic [127:0] rk_rdata;
    logic [3:0]   r_rnd, n_rnd;
    logic         r_rk_ok;

    logic [127:0] r_s;
    logic [127:0] sb, sr, mc, rk;
    logic [63:0]  r_oh, r_ol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key[0] <= '0;
            r_key[1] <= '0;
            r_key[2] <= '0;
            r_key[3] <= '0;
            r_mode   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                aes_pkg::REG_KEY0: r_key[0] <= i_cfg_data;
                aes_pkg::REG_KEY1: r_key[1] <= i_cfg_data;
                aes_pkg::REG_KEY2: r_key[2] <= i_cfg_data;
                aes_pkg::REG_KEY3: r_key[3] <= i_cfg_data;
                aes_pkg::REG_MODE: r_mode   <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (r_mode)
            2'd0:    begin nk = 4'd4; nr = 4'd10; end
            2'd1:    begin nk = 4'd6; nr = 4'd12; end
            default: begin nk = 4'd8; nr = 4'd14; end
        endcase
        total = 6'({2'b0, nr} + 6'd1) << 2;
    end

    // words for i >= nk; r_win[0] is w[i-1], r_win[k] is w[i-1-k]
    always_comb begin
        prev = r_win[0];
        back = r_win[3'(nk - 4'd1)];
        if (r_emod == 4'd0) begin
            tw = aes_pkg::sub_word({prev[23:0], prev[31:24]})
                 ^ {aes_pkg::rcon(r_ediv), 24'h0};
        end else if (nk == 4'd8 && r_emod == 4'd4) begin
            tw = aes_pkg::sub_word(prev);
        end else begin
            tw = prev;
        end
        if (r_ei < 6'(nk)) begin
            w = r_ei[0] ? r_key[r_ei[2:1]][31:0] : r_key[r_ei[2:1]][63:32];
        end else begin
            w = back ^ tw;
        end
    end

    assign o_status.exp_last = (r_ei == total - 6'd1);
    assign o_status.rnd_last = (r_rnd == nr);

    always_ff @(posedge i_clk) begin
        if (i_cmd.exp_start) begin
            r_ei   <= '0;
            r_emod <= '0;
            r_ediv <= '0;
        end else if (i_cmd.exp_step) begin
            r_ei <= r_ei + 6'd1;
            if (r_emod == nk - 4'd1) begin
                r_emod <= '0;
                r_ediv <= r_ediv + 4'd1;
            end else begin
                r_emod <= r_emod + 4'd1;
            end
            r_win[0] <= w;
            for (int k = 1; k < 8; k++) begin
                r_win[k] <= r_win[k-1];
            end
        end
    end

    // a full row is written with its fourth word; words past the store read as zero
    always_comb begin
        rk_we    = i_cmd.exp_step && (r_ei[1:0] == 2'd3) && (32'(r_ei[5:2]) < ROW_DEPTH);
        rk_wdata = {r_win[2], r_win[1], r_win[0], w};
        for (int c = 0; c < 4; c++) begin
            if (32'({r_ei[5:2], 2'(c)}) >= ROUND_KEY_WORDS) begin
                rk_wdata[127-32*c -: 32] = 32'h0;
            end
        end
    end

    // read address runs one step ahead so the row for r_rnd is on rk_rdata
    always_comb begin
        if (i_cmd.blk_load) begin
            n_rnd = '0;
        end else if (i_cmd.key_add || i_cmd.rnd_step) begin
            n_rnd = r_rnd + 4'd1;
        end else begin
            n_rnd = r_rnd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rnd   <= '0;
            r_rk_ok <= 1'b0;
        end else begin
            r_rnd   <= n_rnd;
            r_rk_ok <= (32'(n_rnd) < ROW_DEPTH);
        end
    end

    aes_ram #(
        .WIDTH (128),
        .DEPTH (ROW_DEPTH)
    ) u_rk_ram (
        .i_clk   (i_clk),
        .i_we    (rk_we),
        .i_waddr (r_ei[AW+1:2]),
        .i_wdata (rk_wdata),
        .i_raddr (n_rnd[AW-1:0]),
        .o_rdata (rk_rdata)
    );

    always_comb begin
        rk = r_rk_ok ? rk_rdata : 128'h0;
        for (int c = 0; c < 4; c++) begin
            sb[127-32*c -: 32] = aes_pkg::sub_word(r_s[127-32*c -: 32]);
        end
        for (int c = 0; c < 4; c++) begin
            sr[127-32*c -: 32] = {sb[127-32*c -: 8],
                                  sb[127-32*((c+1)%4)-8 -: 8],
                                  sb[127-32*((c+2)%4)-16 -: 8],
                                  sb[127-32*((c+3)%4)-24 -: 8]};
            mc[127-32*c -: 32] = aes_pkg::mix_col(sr[127-32*c -: 32]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.blk_load) begin
            r_s <= {i_plain_high, i_plain_low};
        end else if (i_cmd.key_add) begin
            r_s <= r_s ^ rk;
        end else if (i_cmd.rnd_step) begin
            r_s <= ((r_rnd == nr) ? sr : mc) ^ rk;
        end
        if (i_cmd.out_load) begin
            r_oh <= r_s[127:64];
            r_ol <= r_s[63:0];
        end
    end

    assign o_cipher_high = r_oh;
    assign o_cipher_low  = r_ol;
endmodule

// File: sim/aes_block_checker.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// AES block encrypt checker
// Watches the key port and both channels of the encryptor. It keeps its own copy
// of the key registers, expands the round keys and computes the ciphertext for
// every accepted plaintext beat. It then compares each accepted ciphertext beat
// with the oldest expected one.
//------------------------------------------------------------------------------
module aes_block_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [63:0] i_plain_high,
    input  logic [63:0] i_plain_low,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [63:0] i_cipher_high,
    input  logic [63:0] i_cipher_low,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [63:0] high;
        logic [63:0] low;
    } t_block;

    logic [7:0]  sub_byte [256];
    logic [31:0] key_sched [60];
    logic [63:0] key_word [4];
    logic [1:0]  key_mode;
    t_block      cipher_q [$];

    function automatic logic [7:0] gf_dbl(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) p ^= a;
            a = gf_dbl(a);
        end
        return p;
    endfunction

    // S-box built from the field inverse and the affine map
    initial begin
        logic [7:0] inv;
        for (int x = 0; x < 256; x++) begin
            inv = 8'h01;
            for (int k = 0; k < 254; k++) inv = gf_mul(inv, 8'(x));
            if (x == 0) inv = 8'h00;
            sub_byte[x] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                        ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
        end
    end

    function automatic logic [31:0] subst_word(input logic [31:0] w);
        return {sub_byte[w[31:24]], sub_byte[w[23:16]], sub_byte[w[15:8]], sub_byte[w[7:0]]};
    endfunction

    function automatic logic [31:0] mix_column(input logic [31:0] w);
        logic [7:0] a0, a1, a2, a3;
        {a0, a1, a2, a3} = w;
        return {gf_dbl(a0 ^ a1) ^ a1 ^ a2 ^ a3,
                gf_dbl(a1 ^ a2) ^ a0 ^ a2 ^ a3,
                gf_dbl(a2 ^ a3) ^ a0 ^ a1 ^ a3,
                gf_dbl(a3 ^ a0) ^ a0 ^ a1 ^ a2};
    endfunction

    function automatic int num_rounds();
        return (key_mode > 2'd2) ? 14 : 10 + 2 * int'(key_mode);
    endfunction

    function automatic void expand_key_schedule();
        int          nk, total;
        logic [31:0] t;
        logic [7:0]  rc;
        nk = num_rounds() - 6;
        total = (num_rounds() + 1) * 4;
        rc = 8'h01;
        for (int i = 0; i < total; i++) begin
            if (i < nk) begin
                key_sched[i] = i[0] ? key_word[i >> 1][31:0] : key_word[i >> 1][63:32];
            end else begin
                t = key_sched[i - 1];
                if (i % nk == 0) begin
                    t = subst_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                    rc = gf_dbl(rc);
                end else if (nk > 6 && i % nk == 4) begin
                    t = subst_word(t);
                end
                key_sched[i] = key_sched[i - nk] ^ t;
            end
        end
    endfunction

    function automatic t_block encrypt_block(input logic [63:0] hi, input logic [63:0] lo);
        logic [31:0] s [4];
        logic [31:0] t [4];
        int          nr;
        nr = num_rounds();
        expand_key_schedule();
        {s[0], s[1], s[2], s[3]} = {hi, lo};
        for (int c = 0; c < 4; c++) s[c] ^= key_sched[c];
        for (int r = 1; r <= nr; r++) begin
            for (int c = 0; c < 4; c++) begin
                t[c] = subst_word({s[c][31:24], s[(c + 1) % 4][23:16],
                                   s[(c + 2) % 4][15:8], s[(c + 3) % 4][7:0]});
            end
            for (int c = 0; c < 4; c++) begin
                s[c] = ((r < nr) ? mix_column(t[c]) : t[c]) ^ key_sched[4 * r + c];
            end
        end
        return '{high: {s[0], s[1]}, low: {s[2], s[3]}};
    endfunction

    always @(posedge i_clk) begin
        t_block got, want;
        if (!i_rst_n) begin
            key_word <= '{default: '0};
            key_mode <= '0;
            cipher_q.delete();
            o_fail_count <= 0;
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    aes_pkg::REG_KEY0, aes_pkg::REG_KEY1,
                    aes_pkg::REG_KEY2, aes_pkg::REG_KEY3:
                        key_word[i_cfg_index[1:0]] <= i_cfg_data;
                    aes_pkg::REG_MODE: key_mode <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                cipher_q.push_back(encrypt_block(i_plain_high, i_plain_low));
            end
            if (i_out_valid && !i_out_stall) begin
                got = '{high: i_cipher_high, low: i_cipher_low};
                if (cipher_q.size() == 0) begin
                    if (o_fail_count < 10) $display("unexpected cipher beat %h", got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = cipher_q.pop_front();
                    if (got != want) begin
                        if (o_fail_count < 10) begin
                            $display("cipher mismatch: high exp %h got %h, low exp %h got %h",
                                     want.high, got.high, want.low, got.low);
                        end
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_pending <= cipher_q.size();
        end
    end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// AES block encrypt testbench
// Drives plaintext beats and key settings into the encryptor with random
// sender gaps and receiver stalls: reset-key blocks, then known-answer blocks for
// all key lengths, then random keys and blocks. The checker predicts and compares.
//------------------------------------------------------------------------------
module testbench;

    localparam int IDLE_LIMIT  = 5000;
    localparam int PHASE_BEATS = 130;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [63:0] plain_high;
    logic [63:0] plain_low;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
    int          fail_count;
    int          pending;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          quiet_cycles;

    aes_block_encrypt uut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_plain_high(plain_high), .i_plain_low(plain_low),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_cipher_high(cipher_high), .o_cipher_low(cipher_low)
    );

    aes_block_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_plain_high(plain_high), .i_plain_low(plain_low),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_cipher_high(cipher_high), .i_cipher_low(cipher_low),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [63:0] rand_word();
        case ($urandom_range(15))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_beat(input logic [63:0] hi, input logic [63:0] lo);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        plain_high <= hi;
        plain_low  <= lo;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // leaves the write enable high; the caller drops it after the last write
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
    endtask

    task automatic load_key(input logic [63:0] k0, input logic [63:0] k1,
                            input logic [63:0] k2, input logic [63:0] k3,
                            input logic [1:0] mode);
        drain();
        write_reg(aes_pkg::REG_KEY0, k0);
        write_reg(aes_pkg::REG_KEY1, k1);
        write_reg(aes_pkg::REG_KEY2, k2);
        write_reg(aes_pkg::REG_KEY3, k3);
        write_reg(aes_pkg::REG_MODE, {62'h0, mode});
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    initial begin
        logic [1:0] mode;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = aes_pkg::REG_KEY0;
        cfg_data = '0;
        in_valid = 1'b0;
        plain_high = '0;
        plain_low = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // blocks on the reset key, before any write
        send_beat('0, '0);
        send_beat('1, '1);
        send_beat(64'h0011223344556677, 64'h8899aabbccddeeff);

        // known-answer blocks, each key length, and the undefined mode value
        for (int m = 0; m < 4; m++) begin
            load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                     64'h1011121314151617, 64'h18191a1b1c1d1e1f, 2'(m));
            send_beat(64'h0011223344556677, 64'h8899aabbccddeeff);
            send_beat('1, '0);
            send_beat('0, '1);
        end

        // writes to indexes past the mode register
        drain();
        for (int k = 1; k <= 3; k++) write_reg(aes_pkg::REG_MODE + 3'(k), '1);
        cfg_we <= 1'b0;
        @(negedge clk);
        send_beat(64'h0011223344556677, 64'h8899aabbccddeeff);

        for (int ph = 0; ph < 12; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            mode = 2'($urandom_range(3));
            if (ph == 1) load_key('0, '0, '0, '0, 2'd2);
            else if (ph == 2) load_key('1, '1, '1, '1, 2'd1);
            else load_key(rand_word(), rand_word(), rand_word(), rand_word(), mode);
            for (int n = 0; n < PHASE_BEATS; n++) send_beat(rand_word(), rand_word());
        end

        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
